// ===== hw/rtl/pni_pkg.sv =====
`timescale 1ns / 1ps

package pni_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 255;
  localparam int unsigned ROM_ENTRIES         = 256;
  localparam int unsigned COLOUR_ENTRIES      = 128;

  // 3 * 255^2 = 195075 needs 18 bits
  localparam int unsigned DIST_W = 18;
  typedef logic [DIST_W-1:0] dist_t;
  localparam dist_t START_BOUND = 18'd99999;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // token handed from cell to cell along the chain
  typedef struct packed {
    logic       vld;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    dist_t      best;
    logic [7:0] idx;
  } pni_tok_t;

  // colour half of the palette, entries 128..255
  localparam logic [7:0] COLOUR_ROM [COLOUR_ENTRIES][3] = '{
    '{8'd0,8'd0,8'd9},       '{8'd2,8'd0,8'd16},      '{8'd4,8'd0,8'd24},
    '{8'd6,8'd0,8'd31},      '{8'd8,8'd0,8'd38},      '{8'd10,8'd0,8'd45},
    '{8'd12,8'd0,8'd53},     '{8'd14,8'd0,8'd60},     '{8'd17,8'd0,8'd67},
    '{8'd19,8'd0,8'd74},     '{8'd21,8'd0,8'd82},     '{8'd23,8'd0,8'd89},
    '{8'd25,8'd0,8'd96},     '{8'd27,8'd0,8'd103},    '{8'd29,8'd0,8'd111},
    '{8'd31,8'd0,8'd118},    '{8'd36,8'd0,8'd120},    '{8'd41,8'd0,8'd121},
    '{8'd46,8'd0,8'd122},    '{8'd51,8'd0,8'd123},    '{8'd56,8'd0,8'd124},
    '{8'd61,8'd0,8'd125},    '{8'd66,8'd0,8'd126},    '{8'd71,8'd0,8'd127},
    '{8'd76,8'd1,8'd128},    '{8'd81,8'd1,8'd129},    '{8'd86,8'd1,8'd130},
    '{8'd91,8'd1,8'd131},    '{8'd96,8'd1,8'd132},    '{8'd101,8'd1,8'd133},
    '{8'd106,8'd1,8'd134},   '{8'd111,8'd1,8'd135},   '{8'd116,8'd1,8'd136},
    '{8'd121,8'd1,8'd136},   '{8'd125,8'd2,8'd137},   '{8'd130,8'd2,8'd137},
    '{8'd135,8'd3,8'd137},   '{8'd139,8'd3,8'd138},   '{8'd144,8'd3,8'd138},
    '{8'd149,8'd4,8'd138},   '{8'd153,8'd4,8'd139},   '{8'd158,8'd5,8'd139},
    '{8'd163,8'd5,8'd139},   '{8'd167,8'd5,8'd140},   '{8'd172,8'd6,8'd140},
    '{8'd177,8'd6,8'd140},   '{8'd181,8'd7,8'd141},   '{8'd186,8'd7,8'd141},
    '{8'd189,8'd10,8'd137},  '{8'd191,8'd13,8'd132},  '{8'd194,8'd16,8'd127},
    '{8'd196,8'd19,8'd121},  '{8'd198,8'd22,8'd116},  '{8'd200,8'd25,8'd111},
    '{8'd203,8'd28,8'd106},  '{8'd205,8'd31,8'd101},  '{8'd207,8'd34,8'd95},
    '{8'd209,8'd37,8'd90},   '{8'd212,8'd40,8'd85},   '{8'd214,8'd43,8'd80},
    '{8'd216,8'd46,8'd75},   '{8'd218,8'd49,8'd69},   '{8'd221,8'd52,8'd64},
    '{8'd223,8'd55,8'd59},   '{8'd224,8'd57,8'd49},   '{8'd225,8'd60,8'd47},
    '{8'd226,8'd64,8'd44},   '{8'd227,8'd67,8'd42},   '{8'd228,8'd71,8'd39},
    '{8'd229,8'd74,8'd37},   '{8'd230,8'd78,8'd34},   '{8'd231,8'd81,8'd32},
    '{8'd231,8'd85,8'd29},   '{8'd232,8'd88,8'd27},   '{8'd233,8'd92,8'd24},
    '{8'd234,8'd95,8'd22},   '{8'd235,8'd99,8'd19},   '{8'd236,8'd102,8'd17},
    '{8'd237,8'd106,8'd14},  '{8'd238,8'd109,8'd12},  '{8'd239,8'd112,8'd12},
    '{8'd240,8'd116,8'd12},  '{8'd240,8'd119,8'd12},  '{8'd241,8'd123,8'd12},
    '{8'd241,8'd127,8'd12},  '{8'd242,8'd130,8'd12},  '{8'd242,8'd134,8'd12},
    '{8'd243,8'd138,8'd12},  '{8'd243,8'd141,8'd13},  '{8'd244,8'd145,8'd13},
    '{8'd244,8'd149,8'd13},  '{8'd245,8'd152,8'd13},  '{8'd245,8'd156,8'd13},
    '{8'd246,8'd160,8'd13},  '{8'd246,8'd163,8'd13},  '{8'd247,8'd167,8'd13},
    '{8'd247,8'd171,8'd13},  '{8'd248,8'd175,8'd14},  '{8'd248,8'd178,8'd15},
    '{8'd249,8'd182,8'd16},  '{8'd249,8'd185,8'd18},  '{8'd250,8'd189,8'd19},
    '{8'd250,8'd192,8'd20},  '{8'd251,8'd196,8'd21},  '{8'd251,8'd199,8'd22},
    '{8'd252,8'd203,8'd23},  '{8'd252,8'd206,8'd24},  '{8'd253,8'd210,8'd25},
    '{8'd253,8'd213,8'd27},  '{8'd254,8'd217,8'd28},  '{8'd254,8'd220,8'd29},
    '{8'd255,8'd224,8'd30},  '{8'd255,8'd227,8'd39},  '{8'd255,8'd229,8'd53},
    '{8'd255,8'd231,8'd67},  '{8'd255,8'd233,8'd81},  '{8'd255,8'd234,8'd95},
    '{8'd255,8'd236,8'd109}, '{8'd255,8'd238,8'd123}, '{8'd255,8'd240,8'd137},
    '{8'd255,8'd242,8'd151}, '{8'd255,8'd244,8'd165}, '{8'd255,8'd246,8'd179},
    '{8'd255,8'd248,8'd193}, '{8'd255,8'd249,8'd207}, '{8'd255,8'd251,8'd221},
    '{8'd255,8'd253,8'd235}, '{8'd255,8'd255,8'd24}
  };

  // entries 0..127 are a grey ramp: 255,253,..,129 then 126,124,..,0
  function automatic rgb_t palette_entry(input logic [7:0] idx);
    logic [7:0] lvl;
    rgb_t       c;
    if (!idx[7]) begin
      if (!idx[6]) begin
        lvl = 8'd255 - {1'b0, idx[5:0], 1'b0};
      end else begin
        lvl = 8'd126 - {1'b0, idx[5:0], 1'b0};
      end
      c = '{r: lvl, g: lvl, b: lvl};
    end else begin
      c = '{r: COLOUR_ROM[idx[6:0]][0],
            g: COLOUR_ROM[idx[6:0]][1],
            b: COLOUR_ROM[idx[6:0]][2]};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pni_cell.sv =====
`timescale 1ns / 1ps

module pni_cell #(
  parameter int unsigned ENTRY = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pni_pkg::pni_tok_t tok_i,
  output pni_pkg::pni_tok_t tok_o
);
  import pni_pkg::*;

  localparam logic [7:0] ENTRY_IDX = ENTRY[7:0];
  localparam rgb_t       PAL       = palette_entry(ENTRY_IDX);

  logic [7:0]  dr, dg, db;
  logic [15:0] sr, sg, sb;
  dist_t       sq_sum;
  logic        win;

  pni_tok_t tok_r;

  always_comb begin
    dr     = (tok_i.red   > PAL.r) ? tok_i.red   - PAL.r : PAL.r - tok_i.red;
    dg     = (tok_i.green > PAL.g) ? tok_i.green - PAL.g : PAL.g - tok_i.green;
    db     = (tok_i.blue  > PAL.b) ? tok_i.blue  - PAL.b : PAL.b - tok_i.blue;
    sr     = {8'd0, dr} * {8'd0, dr};
    sg     = {8'd0, dg} * {8'd0, dg};
    sb     = {8'd0, db} * {8'd0, db};
    sq_sum = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
    // strictly smaller only, so the lower index keeps a tie
    win    = (sq_sum < tok_i.best);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
    end
    tok_r.red   <= tok_i.red;
    tok_r.green <= tok_i.green;
    tok_r.blue  <= tok_i.blue;
    tok_r.best  <= win ? sq_sum : tok_i.best;
    tok_r.idx   <= win ? ENTRY_IDX : tok_i.idx;
  end

  assign tok_o = tok_r;

endmodule

// ===== hw/rtl/palette_nearest_index.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; busy is held low, a new pixel may enter every cycle.
// One cell per palette entry, each a register stage comparing against its ROM colour.
// Reset (synchronous, rst_n low) clears the valid bits along the chain; pixels in flight are lost.
// The receiver cannot stall: out_valid is a single-cycle strobe.
module palette_nearest_index #(
  parameter int unsigned PALETTE_ENTRIES = pni_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  output logic [7:0] out_palette_index
);
  import pni_pkg::*;

  localparam int unsigned NCELL =
    (PALETTE_ENTRIES > ROM_ENTRIES) ? ROM_ENTRIES : PALETTE_ENTRIES;

  pni_tok_t chain [NCELL+1];

  assign busy = 1'b0;

  assign chain[0] = '{vld:   start && !busy,
                      red:   in_red,
                      green: in_green,
                      blue:  in_blue,
                      best:  START_BOUND,
                      idx:   8'd0};

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    pni_cell #(
      .ENTRY(k)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(chain[k]),
      .tok_o(chain[k+1])
    );
  end

  assign out_valid         = chain[NCELL].vld;
  assign out_palette_index = chain[NCELL].idx;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_palette_index} < 9'(NCELL)))
    else $error("palette index beyond searched entries");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (chain[NCELL].best <= START_BOUND))
    else $error("best distance above start bound");

  a_chain_flow: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NCELL-1].vld |=> out_valid)
    else $error("transfer dropped at last cell");

  a_idx_zero_when_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && chain[NCELL].best == START_BOUND) |-> (out_palette_index == 8'd0))
    else $error("index moved without a better match");

endmodule

// ===== dv/palette_nearest_index_tb.sv =====
`timescale 1ns / 1ps

module palette_nearest_index_tb;
  import pni_pkg::*;

  localparam int unsigned PALETTE_SIZE = PALETTE_ENTRIES_DEF;
  localparam int unsigned CHAIN_DEPTH  = (PALETTE_SIZE < 256) ? PALETTE_SIZE : 256;
  localparam int unsigned DIST_LIMIT   = 99999;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1700;

  // iron-black colour half of the palette, entries 128..255
  localparam bit [7:0] IRON_COLOURS [128][3] = '{
    '{0,0,9},'{2,0,16},'{4,0,24},'{6,0,31},'{8,0,38},'{10,0,45},'{12,0,53},'{14,0,60},
    '{17,0,67},'{19,0,74},'{21,0,82},'{23,0,89},'{25,0,96},'{27,0,103},'{29,0,111},
    '{31,0,118},'{36,0,120},'{41,0,121},'{46,0,122},'{51,0,123},'{56,0,124},'{61,0,125},
    '{66,0,126},'{71,0,127},'{76,1,128},'{81,1,129},'{86,1,130},'{91,1,131},'{96,1,132},
    '{101,1,133},'{106,1,134},'{111,1,135},'{116,1,136},'{121,1,136},'{125,2,137},
    '{130,2,137},'{135,3,137},'{139,3,138},'{144,3,138},'{149,4,138},'{153,4,139},
    '{158,5,139},'{163,5,139},'{167,5,140},'{172,6,140},'{177,6,140},'{181,7,141},
    '{186,7,141},'{189,10,137},'{191,13,132},'{194,16,127},'{196,19,121},'{198,22,116},
    '{200,25,111},'{203,28,106},'{205,31,101},'{207,34,95},'{209,37,90},'{212,40,85},
    '{214,43,80},'{216,46,75},'{218,49,69},'{221,52,64},'{223,55,59},'{224,57,49},
    '{225,60,47},'{226,64,44},'{227,67,42},'{228,71,39},'{229,74,37},'{230,78,34},
    '{231,81,32},'{231,85,29},'{232,88,27},'{233,92,24},'{234,95,22},'{235,99,19},
    '{236,102,17},'{237,106,14},'{238,109,12},'{239,112,12},'{240,116,12},'{240,119,12},
    '{241,123,12},'{241,127,12},'{242,130,12},'{242,134,12},'{243,138,12},'{243,141,13},
    '{244,145,13},'{244,149,13},'{245,152,13},'{245,156,13},'{246,160,13},'{246,163,13},
    '{247,167,13},'{247,171,13},'{248,175,14},'{248,178,15},'{249,182,16},'{249,185,18},
    '{250,189,19},'{250,192,20},'{251,196,21},'{251,199,22},'{252,203,23},'{252,206,24},
    '{253,210,25},'{253,213,27},'{254,217,28},'{254,220,29},'{255,224,30},'{255,227,39},
    '{255,229,53},'{255,231,67},'{255,233,81},'{255,234,95},'{255,236,109},'{255,238,123},
    '{255,240,137},'{255,242,151},'{255,244,165},'{255,246,179},'{255,248,193},
    '{255,249,207},'{255,251,221},'{255,253,235},'{255,255,24}
  };

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] index;
  } pixel_match_t;

  // palette colour of one entry: grey ramp below 128, iron colours above
  function automatic void iron_colour(input int unsigned entry,
                                      output int unsigned r, g, b);
    int unsigned lvl;
    if (entry < 64) begin
      lvl = 255 - 2 * entry;
      r = lvl; g = lvl; b = lvl;
    end else if (entry < 128) begin
      lvl = 126 - 2 * (entry - 64);
      r = lvl; g = lvl; b = lvl;
    end else begin
      r = 32'(IRON_COLOURS[7'(entry - 128)][0]);
      g = 32'(IRON_COLOURS[7'(entry - 128)][1]);
      b = 32'(IRON_COLOURS[7'(entry - 128)][2]);
    end
  endfunction

  class pixel_scoreboard;
    pixel_match_t pending_q[$];
    int unsigned  mismatches;

    function bit [7:0] nearest_entry(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      int unsigned best, sq_sum, pr, pg, pb;
      int          dr, dg, db;
      bit [7:0]    best_idx;
      best     = DIST_LIMIT;
      best_idx = '0;
      for (int unsigned i = 0; i < CHAIN_DEPTH; i++) begin
        iron_colour(i, pr, pg, pb);
        dr     = int'(pr) - int'(r);
        dg     = int'(pg) - int'(g);
        db     = int'(pb) - int'(b);
        sq_sum = dr * dr + dg * dg + db * db;
        // strict compare: lowest index keeps a tie
        if (sq_sum < best) begin
          best     = sq_sum;
          best_idx = i[7:0];
        end
      end
      return best_idx;
    endfunction

    function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      pixel_match_t m;
      m.red   = r;
      m.green = g;
      m.blue  = b;
      m.index = nearest_entry(r, g, b);
      pending_q = {pending_q, m};
    endfunction

    function void check_index(bit [7:0] actual);
      pixel_match_t m;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: palette_index %0d", actual);
        return;
      end
      m = pending_q.pop_front();
      if (actual !== m.index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pixel (%0d,%0d,%0d) expected index %0d, got %0d",
                   m.red, m.green, m.blue, m.index, actual);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic       out_valid;
  logic [7:0] out_palette_index;

  int unsigned     cycles = 0;
  pixel_scoreboard match_sb = new();

  always #10 clk = ~clk;

  palette_nearest_index u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_palette_index (out_palette_index)
  );

  // transfers are sampled right after the edge, before any NBA update
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      match_sb.note_pixel(in_red, in_green, in_blue);
    if (rst_n && out_valid)
      match_sb.check_index(out_palette_index);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("palette_nearest_index_tb NOT OK");
      $finish;
    end
  end

  // start stays high across back-to-back pixels within a burst
  task automatic send_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_chain();
    start <= 1'b0;
    @(posedge clk);
    while (match_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  task automatic send_random_pixel();
    int unsigned kind, entry, pr, pg, pb, lvl;
    int          spread;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end else if (kind < 8) begin
      // near a palette colour, where neighbouring entries compete closely
      entry  = $urandom_range(0, PALETTE_SIZE - 1);
      spread = $urandom_range(0, 8);
      iron_colour(entry, pr, pg, pb);
      send_pixel(clamp_byte(int'(pr) + $urandom_range(0, 2 * spread) - spread),
                 clamp_byte(int'(pg) + $urandom_range(0, 2 * spread) - spread),
                 clamp_byte(int'(pb) + $urandom_range(0, 2 * spread) - spread));
    end else begin
      // near-grey pixels hit ties between ramp steps
      lvl = $urandom_range(0, 255);
      send_pixel(8'(lvl), clamp_byte(int'(lvl) + $urandom_range(0, 2) - 1),
                 clamp_byte(int'(lvl) + $urandom_range(0, 2) - 1));
    end
  endtask

  initial begin
    int unsigned sent, burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, exact palette colours and grey ties
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd1,   8'd1,   8'd1);
    idle_for(3);
    send_pixel(8'd0,   8'd0,   8'd9);
    send_pixel(8'd0,   8'd0,   8'd4);
    send_pixel(8'd255, 8'd255, 8'd24);
    send_pixel(8'd255, 8'd253, 8'd235);
    send_pixel(8'd186, 8'd7,   8'd141);
    send_pixel(8'd223, 8'd55,  8'd59);
    send_pixel(8'd170, 8'd85,  8'd85);
    send_pixel(8'd85,  8'd170, 8'd85);
    send_pixel(8'd85,  8'd85,  8'd170);
    drain_chain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_pixel();
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2)
        drain_chain();
      else if ($urandom_range(0, 9) >= 3)
        idle_for($urandom_range(1, 12));
    end

    drain_chain();
    repeat (CHAIN_DEPTH + 20) @(posedge clk);
    if (match_sb.pending() != 0)
      match_sb.mismatches += match_sb.pending();
    if (match_sb.mismatches == 0) begin
      $display("palette_nearest_index_tb OK");
    end else begin
      $display("palette_nearest_index_tb NOT OK");
    end
    $finish;
  end

endmodule
